// ----- hw/rtl/tcp_port_process_filter_assert.svh -----
// Assertion macros shared by the port filter RTL.
`ifndef TCP_PORT_PROCESS_FILTER_ASSERT_SVH
`define TCP_PORT_PROCESS_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TPPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TPPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tppf_pkg.sv -----
// Package: types and constants of the TCP port process filter.
`default_nettype none

package tppf_pkg;

    localparam int unsigned INDEX_W = 7;

    localparam logic [INDEX_W-1:0] ETH_HDR_LEN = 7'd14;
    localparam logic [INDEX_W-1:0] IP_MIN_LEN  = 7'd20;
    localparam logic [INDEX_W-1:0] TCP_MIN_LEN = 7'd20;
    localparam logic [INDEX_W-1:0] COUNT_LIMIT = 7'd94;
    localparam logic [INDEX_W-1:0] POS_ETYPE_HI = 7'd12;
    localparam logic [INDEX_W-1:0] POS_ETYPE_LO = 7'd13;
    localparam logic [INDEX_W-1:0] POS_PROTOCOL = 7'd23;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_PERMIT_PORT = 1'b0,
        REG_WATCHED_PID = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CAUSE_SHORT_ETH = 3'd0,
        CAUSE_NOT_IPV4  = 3'd1,
        CAUSE_SHORT_IP  = 3'd2,
        CAUSE_NOT_TCP   = 3'd3,
        CAUSE_SHORT_TCP = 3'd4,
        CAUSE_OTHER_PID = 3'd5,
        CAUSE_PORT_OK   = 3'd6,
        CAUSE_DROPPED   = 3'd7
    } cause_t;

    typedef struct packed {
        logic [7:0]  packet_byte;
        logic        end_of_frame;
        logic [31:0] owner_pid;
    } item_t;

    typedef struct packed {
        logic        verdict;
        cause_t      cause;
        logic [15:0] source_port;
        logic [15:0] dest_port;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcp_port_process_filter.sv -----
// Top level: Ethernet/IPv4/TCP port filter for one process, one frame byte per transaction.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+---------------------------------
//  item     | item_valid / item_stall        | item   (byte, end mark, pid)
//  result   | result_valid / result_stall    | result (verdict, cause, ports)
//  config   | cfg_write_en                   | cfg_index, cfg_data
//
//  One transaction per clock unless a final byte is held: each byte is registered,
//  then parsed in one pass into the frame state; the final byte writes the verdict
//  to the result register. A final byte is first taken into the input register;
//  once parsed, its verdict goes into the result register and result_valid rises.
//  Reset clears the frame state, the configuration and both valid flags.
//  Only a final byte waits on a stalled result; other bytes keep flowing while
//  a verdict sits in the result register.
`default_nettype none
`include "tcp_port_process_filter_assert.svh"

module tcp_port_process_filter
    import tppf_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire item_t         item,
    output logic               result_valid,
    input  wire logic          result_stall,
    output result_t            result,
    input  wire logic          cfg_write_en,
    input  wire logic [0:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    // Configuration
    logic [15:0] permit_port_reg;
    logic [31:0] watched_pid_reg;

    // Input register
    logic  in_valid_reg;
    item_t in_item_reg;

    // Frame state
    logic [INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0]        ether_kind_reg, ether_kind_next;
    logic [7:0]         ip_protocol_reg, ip_protocol_next;
    logic [3:0]         header_words_reg, header_words_next;
    logic [15:0]        src_port_reg, src_port_next;
    logic [15:0]        dst_port_reg, dst_port_next;

    // Result register
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg, out_result_next;

    logic               in_hold;
    logic               in_fire;
    logic               take;
    logic [INDEX_W-1:0] tcp_at;
    logic [INDEX_W-1:0] pos;
    logic [7:0]         b;

    // Hold a final byte while an earlier verdict is still stalled.
    assign in_hold    = in_valid_reg && in_item_reg.end_of_frame
                        && out_valid_reg && result_stall;
    assign in_fire    = in_valid_reg && !in_hold;
    assign item_stall = in_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            permit_port_reg <= '0;
            watched_pid_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PERMIT_PORT: permit_port_reg <= cfg_data[15:0];
                REG_WATCHED_PID: watched_pid_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: load whenever not held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_hold)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_hold && item_valid)
        begin
            in_item_reg <= item;
        end
    end

    // Parse one byte. The IHL captured by this very byte already steers
    // the TCP offset, so a zero IHL makes byte 14 the source port high byte.
    always_comb
    begin
        pos  = byte_index_reg;
        b    = in_item_reg.packet_byte;
        take = pos < COUNT_LIMIT;

        ether_kind_next   = ether_kind_reg;
        ip_protocol_next  = ip_protocol_reg;
        header_words_next = header_words_reg;
        src_port_next     = src_port_reg;
        dst_port_next     = dst_port_reg;
        byte_index_next   = byte_index_reg;

        if (take)
        begin
            if (pos == POS_ETYPE_HI) ether_kind_next[15:8] = b;
            if (pos == POS_ETYPE_LO) ether_kind_next[7:0]  = b;
            if (pos == ETH_HDR_LEN)  header_words_next     = b[3:0];
            if (pos == POS_PROTOCOL) ip_protocol_next      = b;
        end

        tcp_at = ETH_HDR_LEN + {1'b0, header_words_next, 2'b00};

        if (take)
        begin
            if (pos == tcp_at)            src_port_next[15:8] = b;
            if (pos == tcp_at + 7'd1)     src_port_next[7:0]  = b;
            if (pos == tcp_at + 7'd2)     dst_port_next[15:8] = b;
            if (pos == tcp_at + 7'd3)     dst_port_next[7:0]  = b;
            byte_index_next = pos + 7'd1;
        end
    end

    // Verdict on the updated frame state
    always_comb
    begin
        out_result_next.verdict     = 1'b0;
        out_result_next.source_port = '0;
        out_result_next.dest_port   = '0;

        if (byte_index_next < ETH_HDR_LEN)
        begin
            out_result_next.cause = CAUSE_SHORT_ETH;
        end
        else if (ether_kind_next != ETHERTYPE_IPV4)
        begin
            out_result_next.cause = CAUSE_NOT_IPV4;
        end
        else if (byte_index_next < ETH_HDR_LEN + IP_MIN_LEN)
        begin
            out_result_next.cause = CAUSE_SHORT_IP;
        end
        else if (ip_protocol_next != PROTO_TCP)
        begin
            out_result_next.cause = CAUSE_NOT_TCP;
        end
        else if (byte_index_next < tcp_at + TCP_MIN_LEN)
        begin
            out_result_next.cause = CAUSE_SHORT_TCP;
        end
        else
        begin
            out_result_next.source_port = src_port_next;
            out_result_next.dest_port   = dst_port_next;
            if (in_item_reg.owner_pid != watched_pid_reg)
            begin
                out_result_next.cause = CAUSE_OTHER_PID;
            end
            else if (src_port_next == permit_port_reg || dst_port_next == permit_port_reg)
            begin
                out_result_next.cause = CAUSE_PORT_OK;
            end
            else
            begin
                out_result_next.cause   = CAUSE_DROPPED;
                out_result_next.verdict = 1'b1;
            end
        end
    end

    // Advance frame state; clear it after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            ether_kind_reg   <= '0;
            ip_protocol_reg  <= '0;
            header_words_reg <= '0;
            src_port_reg     <= '0;
            dst_port_reg     <= '0;
        end
        else if (in_fire)
        begin
            if (in_item_reg.end_of_frame)
            begin
                byte_index_reg   <= '0;
                ether_kind_reg   <= '0;
                ip_protocol_reg  <= '0;
                header_words_reg <= '0;
                src_port_reg     <= '0;
                dst_port_reg     <= '0;
            end
            else
            begin
                byte_index_reg   <= byte_index_next;
                ether_kind_reg   <= ether_kind_next;
                ip_protocol_reg  <= ip_protocol_next;
                header_words_reg <= header_words_next;
                src_port_reg     <= src_port_next;
                dst_port_reg     <= dst_port_next;
            end
        end
    end

    // Result register: fill on a final byte, drain when taken
    assign out_valid_next = (in_fire && in_item_reg.end_of_frame)
                            || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_item_reg.end_of_frame)
        begin
            out_result_reg <= out_result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;

    // Checks
    `TPPF_ASSERT_NOW(a_index_saturates, 1'b1, byte_index_reg <= COUNT_LIMIT,
        "byte index ran past its limit")
    `TPPF_ASSERT_NEXT(a_clear_after_frame, in_fire && in_item_reg.end_of_frame,
        byte_index_reg == '0 && header_words_reg == '0 && out_valid_reg,
        "frame state not cleared or verdict lost after final byte")
    `TPPF_ASSERT_NOW(a_ports_zero_when_short,
        out_valid_reg && out_result_reg.cause != CAUSE_OTHER_PID
        && out_result_reg.cause != CAUSE_PORT_OK && out_result_reg.cause != CAUSE_DROPPED,
        out_result_reg.source_port == '0 && out_result_reg.dest_port == '0
        && !out_result_reg.verdict,
        "ports or drop reported for a frame that never reached TCP")

endmodule

`default_nettype wire

// ----- sim/tcp_port_process_filter_chk.sv -----
// Checker: predicts the port filter verdicts from the observed traffic and compares results.
module tcp_port_process_filter_chk
    import tppf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  item_t       item,
    input  logic        result_valid,
    input  logic        result_stall,
    input  result_t     result,
    input  logic        cfg_write_en,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int unsigned mismatches,
    output int unsigned pending,
    output int unsigned verdicts,
    output int unsigned drops
);

    logic [15:0] permit_port;
    logic [31:0] watched_pid;

    // frame being parsed
    logic [6:0]  byte_count;
    logic [15:0] ether_kind;
    logic [7:0]  ip_proto;
    logic [3:0]  ihl;
    logic [15:0] src_port;
    logic [15:0] dst_port;

    result_t     verdict_q[$];

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic clear_frame();
        byte_count = '0;
        ether_kind = '0;
        ip_proto   = '0;
        ihl        = '0;
        src_port   = '0;
        dst_port   = '0;
    endtask

    task automatic absorb_byte(input item_t it);
        logic [6:0] pos;
        logic [6:0] tcp_at;
        logic [6:0] len;
        result_t    verdict;
        if (byte_count < COUNT_LIMIT)
        begin
            pos = byte_count;
            if (pos == POS_ETYPE_HI) ether_kind[15:8] = it.packet_byte;
            if (pos == POS_ETYPE_LO) ether_kind[7:0] = it.packet_byte;
            if (pos == ETH_HDR_LEN) ihl = it.packet_byte[3:0];
            if (pos == POS_PROTOCOL) ip_proto = it.packet_byte;
            // the header length may have been taken from this very byte
            tcp_at = ETH_HDR_LEN + {1'b0, ihl, 2'b00};
            if (pos == tcp_at) src_port[15:8] = it.packet_byte;
            if (pos == tcp_at + 7'd1) src_port[7:0] = it.packet_byte;
            if (pos == tcp_at + 7'd2) dst_port[15:8] = it.packet_byte;
            if (pos == tcp_at + 7'd3) dst_port[7:0] = it.packet_byte;
            byte_count = byte_count + 7'd1;
        end
        if (it.end_of_frame)
        begin
            len = byte_count;
            verdict = '0;
            if (len < ETH_HDR_LEN)
                verdict.cause = CAUSE_SHORT_ETH;
            else if (ether_kind != ETHERTYPE_IPV4)
                verdict.cause = CAUSE_NOT_IPV4;
            else if (len < ETH_HDR_LEN + IP_MIN_LEN)
                verdict.cause = CAUSE_SHORT_IP;
            else if (ip_proto != PROTO_TCP)
                verdict.cause = CAUSE_NOT_TCP;
            else if (len < ETH_HDR_LEN + {1'b0, ihl, 2'b00} + TCP_MIN_LEN)
                verdict.cause = CAUSE_SHORT_TCP;
            else
            begin
                verdict.source_port = src_port;
                verdict.dest_port   = dst_port;
                if (it.owner_pid != watched_pid)
                    verdict.cause = CAUSE_OTHER_PID;
                else if (src_port == permit_port || dst_port == permit_port)
                    verdict.cause = CAUSE_PORT_OK;
                else
                begin
                    verdict.cause   = CAUSE_DROPPED;
                    verdict.verdict = 1'b1;
                end
            end
            verdict_q.push_back(verdict);
            clear_frame();
        end
    endtask

    task automatic check_verdict(input result_t got);
        result_t want;
        if (verdict_q.size() == 0)
        begin
            report($sformatf("result %0h with no frame outstanding", got));
        end
        else
        begin
            want = verdict_q.pop_front();
            if (got.verdict !== want.verdict)
                report($sformatf("verdict %0b, expected %0b", got.verdict, want.verdict));
            if (got.cause !== want.cause)
                report($sformatf("cause %0d, expected %0d", got.cause, want.cause));
            if (got.source_port !== want.source_port)
                report($sformatf("source port %0h, expected %0h",
                                 got.source_port, want.source_port));
            if (got.dest_port !== want.dest_port)
                report($sformatf("dest port %0h, expected %0h",
                                 got.dest_port, want.dest_port));
            verdicts++;
            if (want.verdict) drops++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            permit_port = '0;
            watched_pid = '0;
            clear_frame();
            verdict_q.delete();
            mismatches = 0;
            verdicts   = 0;
            drops      = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_PERMIT_PORT: permit_port = cfg_data[15:0];
                    REG_WATCHED_PID: watched_pid = cfg_data;
                    default: ;
                endcase
            end
            if (result_valid && !result_stall) check_verdict(result);
            if (item_valid && !item_stall) absorb_byte(item);
            pending = verdict_q.size();
        end
    end

endmodule

// ----- sim/tcp_port_process_filter_tb.sv -----
// Testbench top: drives frames and register settings into the port filter and gives the verdict.
module tcp_port_process_filter_tb;
    import tppf_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned BYTE_TARGET  = 1100;
    localparam int unsigned FRAME_TARGET = 60;
    localparam int unsigned PHASES       = 5;
    // settle margin before the registers are written
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_CYCLES  = 8;

    // receiver behaviour: never stall, stall at random, or stall in long runs
    typedef enum int unsigned {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS
    } stall_mode_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_write_en = 1'b0;
    logic [0:0]  cfg_index    = '0;
    logic [31:0] cfg_data     = '0;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned verdicts;
    int unsigned drops;

    int unsigned cycles        = 0;
    int unsigned bytes_sent    = 0;
    int unsigned frames_sent   = 0;
    int unsigned settings_used = 0;

    // register values last written, used to aim the stimulus
    logic [15:0] cur_port = '0;
    logic [31:0] cur_pid  = '0;

    // bytes of the frame about to be sent
    logic [7:0]  frame_q[$];

    // sender burst bookkeeping
    int unsigned burst_left = 0;

    // receiver stall bookkeeping
    stall_mode_t stall_mode = STALL_NONE;
    int unsigned mode_left  = 0;
    int unsigned run_left   = 0;
    logic        stall_hold = 1'b0;

    always #5 clk = ~clk;

    tcp_port_process_filter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tcp_port_process_filter_chk i_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .verdicts     (verdicts),
        .drops        (drops)
    );

    // Receiver: switch between stall behaviours, each kept for a stretch of random length, so that
    // stalls land on every phase of the work and some stretches have none at all.
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 2));
            mode_left  = $urandom_range(40, 400);
        end
        else
            mode_left--;
        case (stall_mode)
            STALL_NONE:   result_stall <= 1'b0;
            STALL_RANDOM: result_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                // hold each level for a run of random length
                if (run_left == 0)
                begin
                    stall_hold = ~stall_hold;
                    run_left   = $urandom_range(1, 20);
                end
                else
                    run_left--;
                result_stall <= stall_hold;
            end
        endcase
    end

    // Watchdog: abandon the run if it hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tcp_port_process_filter_tb NOT OK");
            $finish;
        end
    end

    // Offer one byte and hold it until the block accepts the transaction.
    // Entered and left at a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] pid);
        int unsigned gap;
        if (burst_left == 0)
        begin
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                     : $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        item_valid <= 1'b1;
        item       <= '{packet_byte: b, end_of_frame: last, owner_pid: pid};
        burst_left--;
        do @(posedge clk); while (item_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Send the whole of frame_q; the owner pid only matters on the final byte,
    // so give the other bytes random pids.
    task automatic send_frame(input logic [31:0] pid);
        int i;
        for (i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1,
                      (i == frame_q.size() - 1) ? pid : $urandom());
        frames_sent++;
    endtask

    task automatic put_byte(input int pos, input logic [7:0] v);
        if (pos < frame_q.size()) frame_q[pos] = v;
    endtask

    // Build a frame of len bytes. Ports go in first, then the header fields, so
    // that with a small header length the headers win where they overlap.
    // A negative fill means random filler bytes.
    task automatic make_frame(input int len, input logic [15:0] etype, input logic [3:0] hw,
                              input logic [7:0] proto, input logic [15:0] sp,
                              input logic [15:0] dp, input int fill);
        int at;
        int i;
        frame_q.delete();
        for (i = 0; i < len; i++)
            frame_q.push_back(fill < 0 ? 8'($urandom()) : 8'(fill));
        at = int'(ETH_HDR_LEN) + 4 * hw;
        put_byte(at,     sp[15:8]);
        put_byte(at + 1, sp[7:0]);
        put_byte(at + 2, dp[15:8]);
        put_byte(at + 3, dp[7:0]);
        put_byte(int'(POS_ETYPE_HI), etype[15:8]);
        put_byte(int'(POS_ETYPE_LO), etype[7:0]);
        if (len > int'(ETH_HDR_LEN))
            frame_q[ETH_HDR_LEN] = {frame_q[ETH_HDR_LEN][7:4], hw};
        put_byte(int'(POS_PROTOCOL), proto);
    endtask

    // One random frame: mostly complete IPv4/TCP frames with random content,
    // some broken at one header, and some plain noise.
    task automatic random_frame();
        int unsigned kind;
        int          len;
        logic [3:0]  hw;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [31:0] pid;
        logic [15:0] etype;
        logic [7:0]  proto;
        kind  = $urandom_range(0, 99);
        hw    = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 4))
                                            : 4'($urandom_range(5, 15));
        sp    = 16'($urandom());
        dp    = 16'($urandom());
        pid   = ($urandom_range(0, 3) == 0) ? $urandom() : cur_pid;
        etype = ETHERTYPE_IPV4;
        proto = PROTO_TCP;
        // aim at the allowed port on either side, or both
        case ($urandom_range(0, 5))
            0: sp = cur_port;
            1: dp = cur_port;
            2:
            begin
                sp = cur_port;
                dp = cur_port;
            end
            default: ;
        endcase
        // mostly a snug fit, sometimes running past the count limit
        len = int'(ETH_HDR_LEN) + 4 * hw + int'(TCP_MIN_LEN)
            + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8));
        if (kind >= 85)
        begin
            len   = $urandom_range(1, 100);
            etype = 16'($urandom());
            proto = 8'($urandom());
            hw    = 4'($urandom());
        end
        else if (kind >= 60)
        begin
            case ($urandom_range(0, 4))
                0: len = $urandom_range(1, 13);
                1: etype = 16'($urandom());
                2: len = $urandom_range(14, 33);
                3: proto = 8'($urandom());
                default:
                begin
                    hw  = 4'($urandom_range(5, 15));
                    len = $urandom_range(34, 14 + 4 * hw + 19);
                end
            endcase
        end
        make_frame(len, etype, hw, proto, sp, dp, -1);
        send_frame(pid);
    endtask

    // Wait until every verdict is back, then wait out the settle count.
    task automatic wait_idle(input int unsigned settle);
        while (pending != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // Write both registers while the block is idle; junk in the upper port bits
    // must be ignored.
    task automatic set_config(input logic [15:0] port, input logic [31:0] pid);
        item_valid   <= 1'b0;
        wait_idle(SETTLE_CYCLES);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_PERMIT_PORT;
        cfg_data     <= {16'($urandom()), port};
        @(negedge clk);
        cfg_index    <= REG_WATCHED_PID;
        cfg_data     <= pid;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        cur_port = port;
        cur_pid  = pid;
        settings_used++;
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned phase_start;
        logic [15:0] port;
        logic [31:0] pid;

        // hold reset, then release it on a falling edge
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames under the reset settings: allowed port 0, target pid 0.
        make_frame(1, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000, 16'h0000, 8'hFF);
        send_frame(32'hFFFF_FFFF);
        make_frame(13, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000, 16'h0000, 8'h00);
        send_frame(32'h0000_0000);
        // ethertype complete, IPv4 header missing
        make_frame(14, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000, 16'h0000, -1);
        send_frame(32'h0000_0000);
        make_frame(60, 16'h86DD, 4'd5, PROTO_TCP, 16'h0001, 16'h0002, -1);
        send_frame(32'h0000_0000);
        make_frame(60, ETHERTYPE_IPV4, 4'd5, 8'd17, 16'h0001, 16'h0002, -1);
        send_frame(32'h0000_0000);
        // TCP header cut short
        make_frame(40, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0001, 16'h0002, -1);
        send_frame(32'h0000_0000);
        // header length zero: the length byte is also the source port high byte
        make_frame(34, ETHERTYPE_IPV4, 4'd0, PROTO_TCP, 16'h1234, 16'h5678, -1);
        send_frame(32'h0000_0000);
        // header length two: the protocol byte doubles as the source port low byte
        make_frame(60, ETHERTYPE_IPV4, 4'd2, PROTO_TCP, 16'hABCD, 16'h0102, -1);
        send_frame(32'h0000_0000);
        // longest header chain, exact fit and one byte short
        make_frame(94, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 16'hFFFF, 16'hFFFF, 8'h00);
        send_frame(32'h0000_0000);
        make_frame(93, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 16'h0001, 16'h0002, -1);
        send_frame(32'h0000_0000);
        // long frame: bytes past the count limit are ignored
        make_frame(130, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 16'h0001, 16'h8000, 8'hFF);
        send_frame(32'h0000_0000);
        make_frame(54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0050, 16'h0051, -1);
        send_frame(32'h0000_0001);
        // allowed port on the source side, then on the destination side
        make_frame(54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000, 16'h1F90, -1);
        send_frame(32'h0000_0000);
        make_frame(54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h1F90, 16'h0000, -1);
        send_frame(32'h0000_0000);

        // Directed frames at the top of both register ranges.
        set_config(16'hFFFF, 32'hFFFF_FFFF);
        make_frame(54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'hFFFF, 16'h0000, -1);
        send_frame(32'hFFFF_FFFF);
        make_frame(54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0000, 16'h0000, 8'h00);
        send_frame(32'hFFFF_FFFF);
        make_frame(54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'h0001, 16'h0002, -1);
        send_frame(32'hFFFF_FFFE);

        // Random part: one register setting per phase, the extremes first.
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    port = 16'hFFFF;
                    pid  = 32'hFFFF_FFFF;
                end
                1:
                begin
                    port = 16'h0000;
                    pid  = 32'h0000_0000;
                end
                default:
                begin
                    port = 16'($urandom());
                    pid  = $urandom();
                end
            endcase
            if (phase != 0) set_config(port, pid);
            phase_start = bytes_sent;
            // the last phase also runs until enough frames have been sent
            while (bytes_sent - phase_start < BYTE_TARGET / PHASES
                   || (phase == PHASES - 1 && frames_sent < FRAME_TARGET))
                random_frame();
        end

        item_valid <= 1'b0;
        wait_idle(DRAIN_CYCLES);

        $display("Sent %0d bytes in %0d frames under %0d register settings.",
                 bytes_sent, frames_sent, settings_used + 1);
        $display("Checked %0d verdicts, %0d of them drops.", verdicts, drops);
        if (mismatches == 0)
            $display("tcp_port_process_filter_tb OK");
        else
            $display("tcp_port_process_filter_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/tppf_pkg.sv
hw/rtl/tcp_port_process_filter.sv
sim/tcp_port_process_filter_chk.sv
sim/tcp_port_process_filter_tb.sv
